// File: sv/xmbt_pkg.sv
// Shared types and constants for the XOR-metric bucket table.
`timescale 1ns / 1ps
`default_nettype none
package xmbt_pkg;

  localparam int unsigned ID_W    = 160;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 64;

  // Register index, taken from paddr bit 3 (one 64-bit register per 8 bytes).
  localparam logic REG_STALE_TIMEOUT = 1'b0;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_EVICT = 1'b1;

  localparam logic [TIME_W-1:0] STALE_TIMEOUT_RST = 64'd900000;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] seen_at;
    logic              active;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_RESP
  } state_e;

endpackage
`default_nettype wire

// File: sv/xor_metric_bucket_table_top.sv
// Peer bucket table: add/refresh and stale eviction over a dual-port entry memory.
`timescale 1ns / 1ps
`default_nettype none
// The number of entries held sets how long a command takes to return its result.
// A new request is taken in the cycle after the result is loaded. The entries
// sit in one memory that is read at one address and written at one address per
// cycle, and a single compare unit (160-bit identifier match for an add, 64-bit
// age subtract and compare for an evict) walks through the held entries one per
// cycle. An add stops at the first match; a miss with room takes a further append
// step. An evict always walks every held entry and compacts survivors in place.
// in_stall_o stays high from acceptance until the result is loaded into the
// output register, which then waits for the consumer on its own.
module xor_metric_bucket_table_top #(
  parameter int unsigned CAPACITY = 20
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [xmbt_pkg::APB_AW-1:0]    paddr,
  input  wire  [xmbt_pkg::APB_DW-1:0]    pwdata,
  output logic [xmbt_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  // requests
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire                            cmd_i,
  input  wire  [31:0]                    id_high_i,
  input  wire  [63:0]                    id_middle_i,
  input  wire  [63:0]                    id_low_i,
  input  wire  [xmbt_pkg::PORT_W-1:0]    node_port_i,
  input  wire  [xmbt_pkg::TIME_W-1:0]    time_stamp_i,
  input  wire                            node_active_i,
  // results
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic                           accepted_o,
  output logic                           was_refresh_o,
  output logic [xmbt_pkg::COUNT_W-1:0]   removed_count_o,
  output logic [xmbt_pkg::COUNT_W-1:0]   entry_count_o,
  output logic                           table_full_o
);
  import xmbt_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  state_e state_q, state_d;

  // request capture
  logic              cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [PORT_W-1:0] port_q;
  logic [TIME_W-1:0] ts_q;
  logic              act_q;

  logic [TIME_W-1:0] timeout_q;

  logic [CW-1:0] held_q, held_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] chk_idx_q, chk_idx_d;
  logic [CW-1:0] kept_q, kept_d;
  logic [CW-1:0] removed_q, removed_d;
  logic          v_q, v_d;
  logic          acc_q, acc_d;
  logic          refresh_q, refresh_d;

  // entry memory
  entry_t          mem [0:CAPACITY-1];
  entry_t          rd_data_q;
  logic            re;
  logic [IW-1:0]   raddr;
  logic            we;
  logic [IW-1:0]   waddr;
  entry_t          wdata;

  // output register
  logic               out_valid_q;
  logic               out_acc_q;
  logic               out_refresh_q;
  logic [COUNT_W-1:0] out_removed_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_full_q;
  logic               out_load;

  logic                 in_take;
  logic                 scan_done;
  logic                 id_hit;
  logic                 stale;
  logic [TIME_W-1:0]    age;
  logic [CW+COUNT_W-1:0] removed_ext;
  logic [CW+COUNT_W-1:0] held_ext;
  entry_t               new_entry;
  entry_t               hit_entry;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && (state_q == ST_IDLE);

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_STALE_TIMEOUT) ? timeout_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= STALE_TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready && (paddr[3] == REG_STALE_TIMEOUT)) begin
      timeout_q <= pwdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= cmd_i;
      id_q   <= {id_high_i, id_middle_i, id_low_i};
      port_q <= node_port_i;
      ts_q   <= time_stamp_i;
      act_q  <= node_active_i;
    end
  end

  // shared compare unit
  assign age       = ts_q - rd_data_q.seen_at;
  assign stale     = (age > timeout_q);
  assign id_hit    = (rd_data_q.id == id_q);
  assign scan_done = (rd_idx_q == held_q) && !v_q;

  always_comb begin
    new_entry.id        = id_q;
    new_entry.port      = port_q;
    new_entry.seen_at   = ts_q;
    new_entry.active    = act_q;
    hit_entry           = rd_data_q;
    hit_entry.seen_at   = ts_q;
    hit_entry.active    = 1'b1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (v_q && (cmd_q == CMD_ADD) && id_hit) begin
          state_d = ST_RESP;
        end else if (scan_done) begin
          if ((cmd_q == CMD_ADD) && (held_q < CAP_CNT)) state_d = ST_APPEND;
          else                                           state_d = ST_RESP;
        end
      end
      ST_APPEND: state_d = ST_RESP;
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    held_d    = held_q;
    rd_idx_d  = rd_idx_q;
    chk_idx_d = chk_idx_q;
    kept_d    = kept_q;
    removed_d = removed_q;
    v_d       = 1'b0;
    acc_d     = acc_q;
    refresh_d = refresh_q;
    re        = 1'b0;
    raddr     = rd_idx_q[IW-1:0];
    we        = 1'b0;
    waddr     = held_q[IW-1:0];
    wdata     = new_entry;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rd_idx_d  = '0;
          kept_d    = '0;
          removed_d = '0;
          acc_d     = 1'b0;
          refresh_d = 1'b0;
        end
      end
      ST_SCAN: begin
        // issue the next read while the previous entry is checked
        if (rd_idx_q != held_q) begin
          re        = 1'b1;
          v_d       = 1'b1;
          chk_idx_d = rd_idx_q;
          rd_idx_d  = rd_idx_q + 1'b1;
        end
        if (v_q) begin
          if (cmd_q == CMD_ADD) begin
            if (id_hit) begin
              we        = 1'b1;
              waddr     = chk_idx_q[IW-1:0];
              wdata     = hit_entry;
              acc_d     = 1'b1;
              refresh_d = 1'b1;
            end
          end else begin
            if (stale) begin
              removed_d = removed_q + 1'b1;
            end else begin
              // compact: survivor moves down to the next kept slot
              we     = 1'b1;
              waddr  = kept_q[IW-1:0];
              wdata  = rd_data_q;
              kept_d = kept_q + 1'b1;
            end
          end
        end
        if (scan_done && (cmd_q == CMD_EVICT)) begin
          held_d = kept_q;
          acc_d  = 1'b1;
        end
      end
      ST_APPEND: begin
        we     = 1'b1;
        waddr  = held_q[IW-1:0];
        wdata  = new_entry;
        held_d = held_q + 1'b1;
        acc_d  = 1'b1;
      end
      ST_RESP: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_data_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      held_q    <= '0;
      rd_idx_q  <= '0;
      chk_idx_q <= '0;
      kept_q    <= '0;
      removed_q <= '0;
      v_q       <= 1'b0;
      acc_q     <= 1'b0;
      refresh_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      rd_idx_q  <= rd_idx_d;
      chk_idx_q <= chk_idx_d;
      kept_q    <= kept_d;
      removed_q <= removed_d;
      v_q       <= v_d;
      acc_q     <= acc_d;
      refresh_q <= refresh_d;
    end
  end

  assign removed_ext = {{COUNT_W{1'b0}}, removed_q};
  assign held_ext    = {{COUNT_W{1'b0}}, held_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_acc_q     <= acc_q;
      out_refresh_q <= refresh_q;
      out_removed_q <= removed_ext[COUNT_W-1:0];
      out_count_q   <= held_ext[COUNT_W-1:0];
      out_full_q    <= (held_q == CAP_CNT);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_acc_q;
  assign was_refresh_o   = out_refresh_q;
  assign removed_count_o = out_removed_q;
  assign entry_count_o   = out_count_q;
  assign table_full_o    = out_full_q;

endmodule
`default_nettype wire
